// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk; CHECK is disabled during rst, CHECK_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("check failed");
`define CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define CHECK(lbl, prop)
`define CHECK_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/fmrdm_pkg.sv =====
package fmrdm_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_IDX_W = $clog2(MOTOR_COUNT);
  localparam int QUEUE_DEPTH = 2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEAD_ZONE   = 2'd0;
  localparam logic [1:0] REG_RAMP_STEP   = 2'd1;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd2;

  localparam logic [15:0] RESET_DEAD_ZONE   = 16'd0;
  localparam logic [15:0] RESET_RAMP_STEP   = 16'd6554;
  localparam logic [15:0] RESET_SPEED_LIMIT = 16'd65535;

  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_STOP  = 1'b1;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [7:0] left_trigger;
    logic [7:0] right_trigger;
  } cmd_t;

  typedef struct packed {
    logic [15:0] duty_right_front;
    logic [15:0] duty_right_back;
    logic [15:0] duty_left_front;
    logic [15:0] duty_left_back;
    logic        dir_right_front;
    logic        dir_right_back;
    logic        dir_left_front;
    logic        dir_left_back;
  } res_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic        stop;
    logic [15:0] dist_sq;
    logic        fwd;
    turn_t       turn;
    logic [7:0]  left;
    logic [7:0]  right;
  } tick_t;

  typedef struct packed {
    logic [15:0] dead_zone;
    logic [15:0] ramp_step;
    logic [15:0] speed_limit;
  } cfg_t;

endpackage

// ===== hdl/fmrdm_front.sv =====
module fmrdm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  fmrdm_pkg::cmd_t  cmd,
  input  logic             q_full,
  output logic             q_push,
  output fmrdm_pkg::tick_t q_data
);

  logic [7:0] last_left;
  logic [7:0] last_right;
  logic [8:0] dx;
  logic [8:0] dy;
  logic [7:0] ax;
  logic [7:0] ay;
  logic [16:0] sq_sum;
  fmrdm_pkg::turn_t turn;

  assign cmd_stall = q_full;
  assign q_push = cmd_valid && !q_full;

  always_comb begin
    dx = {1'b0, cmd.stick_x} - 9'd128;
    dy = {1'b0, cmd.stick_y} - 9'd128;
    ax = dx[8] ? 8'(-dx) : dx[7:0];
    ay = dy[8] ? 8'(-dy) : dy[7:0];
    // at most 2 * 128^2, fits in 16 bits
    sq_sum = 17'(ax * ax) + 17'(ay * ay);
  end

  always_comb begin
    if (cmd.left_trigger == 8'd0 && cmd.right_trigger == 8'd0) begin
      turn = fmrdm_pkg::TURN_NONE;
    end else if (cmd.left_trigger > cmd.right_trigger) begin
      turn = fmrdm_pkg::TURN_LEFT;
    end else if (cmd.left_trigger < cmd.right_trigger) begin
      turn = fmrdm_pkg::TURN_RIGHT;
    end else if (cmd.left_trigger > last_left && cmd.right_trigger <= last_right) begin
      turn = fmrdm_pkg::TURN_LEFT;
    end else if (cmd.right_trigger > last_right && cmd.left_trigger <= last_left) begin
      turn = fmrdm_pkg::TURN_RIGHT;
    end else begin
      turn = fmrdm_pkg::TURN_NONE;
    end
  end

  always_comb begin
    q_data.stop    = (cmd.operation == fmrdm_pkg::OP_STOP);
    q_data.dist_sq = sq_sum[15:0];
    q_data.fwd     = (cmd.stick_y < 8'd128) || (cmd.stick_y == 8'd128 && cmd.stick_x > 8'd128);
    q_data.turn    = turn;
    q_data.left    = cmd.left_trigger;
    q_data.right   = cmd.right_trigger;
  end

  // trigger history follows drive ticks only
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= 8'd0;
      last_right <= 8'd0;
    end else if (q_push && cmd.operation == fmrdm_pkg::OP_DRIVE) begin
      last_left  <= cmd.left_trigger;
      last_right <= cmd.right_trigger;
    end
  end

endmodule

// ===== hdl/fmrdm_queue.sv =====
`include "assert_macros.svh"
module fmrdm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fmrdm_pkg::tick_t push_data,
  input  logic             pop,
  output fmrdm_pkg::tick_t pop_data,
  output logic             full,
  output logic             empty
);

  fmrdm_pkg::tick_t slot [fmrdm_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'(fmrdm_pkg::QUEUE_DEPTH));
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  `CHECK(no_pop_when_empty, pop |-> !empty)
  `CHECK(no_push_when_full, push |-> !full)
  `CHECK(count_bounded, count <= 2'(fmrdm_pkg::QUEUE_DEPTH))

endmodule

// ===== hdl/fmrdm_back.sv =====
`include "assert_macros.svh"
module fmrdm_back (
  input  logic             clk,
  input  logic             rst,
  input  fmrdm_pkg::cfg_t  cfg,
  input  logic             q_empty,
  input  fmrdm_pkg::tick_t q_data,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_stall,
  output fmrdm_pkg::res_t  res
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DZSQ, ST_DZCMP, ST_P1, ST_P2, ST_P3, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_TRAVEL, MODE_SPIN, MODE_HOLD, MODE_COAST
  } mode_t;

  state_t state;
  mode_t  mode;
  fmrdm_pkg::tick_t tick;
  logic [fmrdm_pkg::MOTOR_IDX_W-1:0] idx;
  logic [15:0] mag [fmrdm_pkg::MOTOR_COUNT];
  logic        dir [fmrdm_pkg::MOTOR_COUNT];

  logic [31:0] dz_sq;
  logic [23:0] m255;
  logic [15:0] rest_sq;
  logic [23:0] lim_rest;
  logic [23:0] lim_t;
  logic [47:0] lhs;
  logic [31:0] rhs_core;

  logic [7:0]  t_cur;
  logic [7:0]  rest;
  logic [7:0]  spin_v;
  logic        want;
  logic [15:0] m_cur;
  logic [15:0] m_down;
  logic [16:0] m_sum;
  logic [15:0] m_up;
  logic        dec;
  logic        inc;
  logic [15:0] mag_next;
  logic        dir_next;
  logic        out_free;

  assign out_free = !res_valid || !res_stall;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_comb begin
    t_cur = 8'd0;
    if (tick.turn == fmrdm_pkg::TURN_LEFT && (idx == 2'd1 || idx == 2'd2)) t_cur = tick.left;
    if (tick.turn == fmrdm_pkg::TURN_RIGHT && (idx == 2'd0 || idx == 2'd3)) t_cur = tick.right;
    rest   = 8'd255 - t_cur;
    spin_v = (tick.turn == fmrdm_pkg::TURN_LEFT) ? tick.left : tick.right;
  end

  // per-motor ramp decision
  always_comb begin
    m_cur  = mag[idx];
    m_down = (m_cur > cfg.ramp_step) ? m_cur - cfg.ramp_step : 16'd0;
    m_sum  = {1'b0, m_cur} + {1'b0, cfg.ramp_step};
    m_up   = m_sum[16] ? 16'hFFFF : m_sum[15:0];
    if (mode == MODE_TRAVEL) want = tick.fwd ? ~idx[0] : idx[0];
    else want = (tick.turn == fmrdm_pkg::TURN_LEFT);
    if (mode == MODE_TRAVEL) begin
      // target side scaled by 2^18 needs 50 bits
      dec = ({2'b00, lhs} > {rhs_core, 18'd0}) || (m255 > lim_rest);
      inc = ({2'b00, lhs} < {rhs_core, 18'd0}) || (m255 < lim_t);
    end else begin
      dec = (m255 > {spin_v, 16'd0}) || (m_cur > cfg.speed_limit);
      inc = (m255 < {spin_v, 16'd0}) || (m_cur < cfg.speed_limit);
    end
    mag_next = m_cur;
    dir_next = dir[idx];
    unique case (mode) inside
      MODE_TRAVEL, MODE_SPIN: begin
        if (dir[idx] != want && m_cur != 16'd0) begin
          mag_next = m_down;
        end else begin
          dir_next = want;
          if (dec) mag_next = m_down;
          else if (inc) mag_next = m_up;
        end
      end
      MODE_COAST: mag_next = m_down;
      default: mag_next = m_cur;
    endcase
  end

  // rhs_core overflows are impossible: 32768 * 65025 < 2^31
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      idx       <= '0;
      mode      <= MODE_HOLD;
      for (int i = 0; i < fmrdm_pkg::MOTOR_COUNT; i++) begin
        mag[i] <= 16'd0;
        dir[i] <= 1'b0;
      end
    end else begin
      if (res_valid && !res_stall && state != ST_OUT) res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            tick <= q_data;
            if (q_data.stop) begin
              for (int i = 0; i < fmrdm_pkg::MOTOR_COUNT; i++) begin
                mag[i] <= 16'd0;
                dir[i] <= 1'b0;
              end
              state <= ST_OUT;
            end else begin
              state <= ST_DZSQ;
            end
          end
        end
        ST_DZSQ: begin
          dz_sq <= cfg.dead_zone * cfg.dead_zone;
          state <= ST_DZCMP;
        end
        ST_DZCMP: begin
          if ({tick.dist_sq, 18'd0} > {2'b00, dz_sq}) mode <= MODE_TRAVEL;
          else if (tick.left != 8'd0 || tick.right != 8'd0) begin
            mode <= (tick.turn == fmrdm_pkg::TURN_NONE) ? MODE_HOLD : MODE_SPIN;
          end else mode <= MODE_COAST;
          idx   <= '0;
          state <= ST_P1;
        end
        ST_P1: begin
          m255     <= {m_cur, 8'd0} - {8'd0, m_cur};
          rest_sq  <= rest * rest;
          lim_rest <= cfg.speed_limit * rest;
          lim_t    <= cfg.speed_limit * t_cur;
          state    <= ST_P2;
        end
        ST_P2: begin
          lhs      <= m255 * m255;
          rhs_core <= tick.dist_sq * rest_sq;
          state    <= ST_P3;
        end
        ST_P3: begin
          mag[idx] <= mag_next;
          dir[idx] <= dir_next;
          if (idx == fmrdm_pkg::MOTOR_IDX_W'(fmrdm_pkg::MOTOR_COUNT - 1)) begin
            state <= ST_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_P1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res.duty_right_front <= dir[0] ? ((mag[0] == 16'd0) ? 16'hFFFF : -mag[0]) : mag[0];
            res.duty_right_back  <= dir[1] ? ((mag[1] == 16'd0) ? 16'hFFFF : -mag[1]) : mag[1];
            res.duty_left_front  <= dir[2] ? ((mag[2] == 16'd0) ? 16'hFFFF : -mag[2]) : mag[2];
            res.duty_left_back   <= dir[3] ? ((mag[3] == 16'd0) ? 16'hFFFF : -mag[3]) : mag[3];
            res.dir_right_front  <= dir[0];
            res.dir_right_back   <= dir[1];
            res.dir_left_front   <= dir[2];
            res.dir_left_back    <= dir[3];
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CHECK(p3_after_p2, (state == ST_P3) |-> ($past(state) == ST_P2))
  `CHECK(sweep_starts_at_zero, (state == ST_DZCMP) |=> (state == ST_P1 && idx == '0))
  `CHECK(pop_only_idle, q_pop |-> (state == ST_IDLE))

endmodule

// ===== hdl/four_motor_ramped_drive_mixer.sv =====
// four-motor ramped drive mixer
// command channel (cmd_valid / cmd_stall / cmd): one control tick per
// transaction, either a drive tick (stick and trigger bytes) or an emergency
// stop. result channel (res_valid / res_stall / res): exactly one transaction
// per command, carrying four locked-antiphase duties and direction bits.
// the front classifies each command (deflection squared, travel sense, turn
// choice) in the cycle it is taken and writes it to a two-entry queue.
// the back sequencer takes one queue entry at a time: a drive tick takes
// the entry, squares the dead zone and compares, then passes each motor
// through the shared multiply stages P1, P2 and P3, then the output state;
// a stop goes from taking the entry straight to the output state. the four
// motors share one set of multipliers.
// commands keep being taken while a result waits, until the queue fills;
// a stalled result holds and the back waits before writing the next one.
// reset (rst, synchronous) zeroes all motors and trigger history, empties
// the queue and loads the register defaults: dead zone 0, ramp step 6554,
// speed limit 65535. the apb port is always ready; writes while busy are
// not guarded.
module four_motor_ramped_drive_mixer (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  fmrdm_pkg::cmd_t cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output fmrdm_pkg::res_t res,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  fmrdm_pkg::cfg_t  cfg;
  fmrdm_pkg::tick_t push_data;
  fmrdm_pkg::tick_t pop_data;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  assign pready = 1'b1;

  // register file, word addressed by paddr[3:2]
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone   <= fmrdm_pkg::RESET_DEAD_ZONE;
      cfg.ramp_step   <= fmrdm_pkg::RESET_RAMP_STEP;
      cfg.speed_limit <= fmrdm_pkg::RESET_SPEED_LIMIT;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        fmrdm_pkg::REG_DEAD_ZONE:   cfg.dead_zone   <= pwdata[15:0];
        fmrdm_pkg::REG_RAMP_STEP:   cfg.ramp_step   <= pwdata[15:0];
        fmrdm_pkg::REG_SPEED_LIMIT: cfg.speed_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fmrdm_pkg::REG_DEAD_ZONE:   prdata = {16'd0, cfg.dead_zone};
      fmrdm_pkg::REG_RAMP_STEP:   prdata = {16'd0, cfg.ramp_step};
      fmrdm_pkg::REG_SPEED_LIMIT: prdata = {16'd0, cfg.speed_limit};
      default:                    prdata = 32'd0;
    endcase
  end

  // classification and trigger history
  fmrdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_push    (push),
    .q_data    (push_data)
  );

  // decouples the front from the back
  fmrdm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // motor ramp sequencer and result register
  fmrdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== tb/sv/four_motor_ramped_drive_mixer_tb.sv =====
`timescale 1ns / 100ps

module four_motor_ramped_drive_mixer_tb;
  import fmrdm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  // directed row: command plus an optional typed-in expectation
  typedef struct {
    cmd_t cmd;
    logic has_fixed;
    res_t fixed;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int error_count = 0;
  int cycle_count = 0;
  int cmds_sent = 0;
  int duties_checked = 0;
  int stops_sent = 0;

  // predictor state: motor magnitudes, directions, trigger history, registers
  logic [15:0] mag [MOTOR_COUNT];
  logic dirn [MOTOR_COUNT];
  logic [7:0] prev_left;
  logic [7:0] prev_right;
  logic [15:0] dz_reg;
  logic [15:0] step_reg;
  logic [15:0] limit_reg;

  res_t duty_queue [$];
  directed_row_t rows [$];

  four_motor_ramped_drive_mixer DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] ramp_down(logic [15:0] m);
    return (m > step_reg) ? m - step_reg : 16'd0;
  endfunction

  function automatic logic [15:0] ramp_up(logic [15:0] m);
    int unsigned v;
    v = m + step_reg;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic turn_t choose_turn(logic [7:0] l, logic [7:0] r);
    if (l == 0 && r == 0) return TURN_NONE;
    if (l > r) return TURN_LEFT;
    if (l < r) return TURN_RIGHT;
    // equal pressure: the one that has just risen wins
    if (l > prev_left && r <= prev_right) return TURN_LEFT;
    if (r > prev_right && l <= prev_left) return TURN_RIGHT;
    return TURN_NONE;
  endfunction

  // a motor facing the wrong way only winds down until it reaches zero
  function automatic logic reversal_pending(int n, logic want);
    if (dirn[n] != want && mag[n] != 0) begin
      mag[n] = ramp_down(mag[n]);
      return 1'b1;
    end
    dirn[n] = want;
    return 1'b0;
  endfunction

  function automatic void travel_ramp(int n, logic want, longint unsigned s,
                                      longint unsigned t);
    longint unsigned m255, lhs, rhs, rest;
    if (reversal_pending(n, want)) return;
    m255 = 64'(mag[n]) * 255;
    rest = 255 - t;
    lhs = m255 * m255;
    rhs = 64'd262144 * s * rest * rest;
    if (lhs > rhs || m255 > 64'(limit_reg) * rest) mag[n] = ramp_down(mag[n]);
    else if (lhs < rhs || m255 < 64'(limit_reg) * t) mag[n] = ramp_up(mag[n]);
  endfunction

  function automatic void spin_ramp(int n, logic want, longint unsigned v);
    longint unsigned m255, goal;
    if (reversal_pending(n, want)) return;
    m255 = 64'(mag[n]) * 255;
    goal = v * 65536;
    if (m255 > goal || mag[n] > limit_reg) mag[n] = ramp_down(mag[n]);
    else if (m255 < goal || mag[n] < limit_reg) mag[n] = ramp_up(mag[n]);
  endfunction

  function automatic res_t predict_duties(cmd_t c);
    longint signed dx, dy;
    longint unsigned s;
    logic fwd;
    logic want [MOTOR_COUNT];
    longint unsigned cut [MOTOR_COUNT];
    turn_t turn;
    logic [15:0] duty [MOTOR_COUNT];
    res_t r;
    if (c.operation == OP_STOP) begin
      for (int n = 0; n < MOTOR_COUNT; n++) begin
        mag[n] = '0;
        dirn[n] = 1'b0;
      end
    end else begin
      dx = longint'(c.stick_x) - 128;
      dy = longint'(c.stick_y) - 128;
      s = dx * dx + dy * dy;
      if (s * 262144 > 64'(dz_reg) * 64'(dz_reg)) begin
        fwd = (dy < 0) || (dy == 0 && dx > 0);
        turn = choose_turn(c.left_trigger, c.right_trigger);
        want[0] = fwd; want[2] = fwd; want[1] = !fwd; want[3] = !fwd;
        for (int n = 0; n < MOTOR_COUNT; n++) cut[n] = 0;
        if (turn == TURN_LEFT) begin
          cut[1] = c.left_trigger; cut[2] = c.left_trigger;
        end else if (turn == TURN_RIGHT) begin
          cut[0] = c.right_trigger; cut[3] = c.right_trigger;
        end
        for (int n = 0; n < MOTOR_COUNT; n++) travel_ramp(n, want[n], s, cut[n]);
      end else if (c.left_trigger != 0 || c.right_trigger != 0) begin
        turn = choose_turn(c.left_trigger, c.right_trigger);
        if (turn == TURN_LEFT) begin
          for (int n = 0; n < MOTOR_COUNT; n++) spin_ramp(n, 1'b1, c.left_trigger);
        end else if (turn == TURN_RIGHT) begin
          for (int n = 0; n < MOTOR_COUNT; n++) spin_ramp(n, 1'b0, c.right_trigger);
        end
      end else begin
        // coast: wind down, keep directions
        for (int n = 0; n < MOTOR_COUNT; n++) mag[n] = ramp_down(mag[n]);
      end
      prev_left = c.left_trigger;
      prev_right = c.right_trigger;
    end
    for (int n = 0; n < MOTOR_COUNT; n++)
      duty[n] = dirn[n] ? ((mag[n] == 0) ? 16'hFFFF : 16'(17'h10000 - mag[n])) : mag[n];
    r.duty_right_front = duty[0];
    r.duty_right_back = duty[1];
    r.duty_left_front = duty[2];
    r.duty_left_back = duty[3];
    r.dir_right_front = dirn[0];
    r.dir_right_back = dirn[1];
    r.dir_left_front = dirn[2];
    r.dir_left_back = dirn[3];
    return r;
  endfunction

  // result side: per-result random wait, field by field comparison
  initial begin
    int wait_left;
    res_t want;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (res_valid && !res_stall) begin
          if (duty_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, res);
            error_count++;
          end else begin
            want = duty_queue.pop_front();
            duties_checked++;
            if (res.duty_right_front !== want.duty_right_front)
              $display("%0t: duty_right_front expected %h actual %h", $time,
                       want.duty_right_front, res.duty_right_front);
            if (res.duty_right_back !== want.duty_right_back)
              $display("%0t: duty_right_back expected %h actual %h", $time,
                       want.duty_right_back, res.duty_right_back);
            if (res.duty_left_front !== want.duty_left_front)
              $display("%0t: duty_left_front expected %h actual %h", $time,
                       want.duty_left_front, res.duty_left_front);
            if (res.duty_left_back !== want.duty_left_back)
              $display("%0t: duty_left_back expected %h actual %h", $time,
                       want.duty_left_back, res.duty_left_back);
            if (res[3:0] !== want[3:0])
              $display("%0t: directions expected %b actual %b", $time,
                       want[3:0], res[3:0]);
            if (res !== want) error_count++;
          end
          // a mix of long stall-free stretches and random waits
          wait_left = (cycle_count % 3000 < 800) ? 0 : $urandom_range(0, 6);
        end else if (res_valid && wait_left > 0) begin
          wait_left--;
        end
        res_stall <= (wait_left > 0);
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DEAD_ZONE: dz_reg = value;
      REG_RAMP_STEP: step_reg = value;
      default: limit_reg = value;
    endcase
  endtask

  task automatic send_cmd(cmd_t c, logic has_fixed, res_t fixed);
    int gap;
    res_t r;
    gap = (cycle_count % 2500 < 600) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    // accepted at this edge; the predictor runs in order of acceptance
    r = predict_duties(c);
    if (has_fixed && r !== fixed) begin
      $display("%0t: table row expected %h predictor %h", $time, fixed, r);
      error_count++;
    end
    duty_queue.push_back(r);
    cmds_sent++;
    if (c.operation == OP_STOP) stops_sent++;
  endtask

  task automatic drain;
    cmd_valid <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cmd_t drive_cmd(logic [7:0] x, logic [7:0] y,
                                     logic [7:0] l, logic [7:0] r);
    cmd_t c;
    c.operation = OP_DRIVE;
    c.stick_x = x; c.stick_y = y; c.left_trigger = l; c.right_trigger = r;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int kind;
    c = cmd_t'({1'b0, $urandom});
    kind = $urandom_range(0, 99);
    c.operation = (kind < 3) ? OP_STOP : OP_DRIVE;
    if (kind < 25) begin
      // near the centre, dead zone and spin behaviour
      c.stick_x = 8'(128 + $urandom_range(0, 16) - 8);
      c.stick_y = 8'(128 + $urandom_range(0, 16) - 8);
    end
    if (kind >= 25 && kind < 40) c.left_trigger = 0;
    if (kind >= 30 && kind < 45) c.right_trigger = 0;
    if (kind >= 45 && kind < 55) c.right_trigger = c.left_trigger;
    return c;
  endfunction

  task automatic add_row(cmd_t c, logic has_fixed, res_t fixed);
    directed_row_t row;
    row.cmd = c; row.has_fixed = has_fixed; row.fixed = fixed;
    rows.push_back(row);
  endtask

  initial begin
    cmd_t c;
    res_t all_zero;
    all_zero = '0;
    for (int n = 0; n < MOTOR_COUNT; n++) begin
      mag[n] = '0;
      dirn[n] = 1'b0;
    end
    prev_left = '0; prev_right = '0;
    dz_reg = RESET_DEAD_ZONE; step_reg = RESET_RAMP_STEP; limit_reg = RESET_SPEED_LIMIT;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table: centre stick with no trigger coasts from reset
    add_row(drive_cmd(8'd128, 8'd128, 8'd0, 8'd0), 1'b1, all_zero);
    c = '0; c.operation = OP_STOP;
    add_row(c, 1'b1, all_zero);
    add_row(drive_cmd(8'd128, 8'd0, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd0, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd255, 8'd128, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd0, 8'd128, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd255, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd255, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd0, 8'd0, 8'd255, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd255, 8'd255, 8'd0, 8'd255), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd200, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd200, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd0, 8'd90), 1'b0, all_zero);
    // equal triggers: rise of one side, then no rise (hold)
    add_row(drive_cmd(8'd128, 8'd128, 8'd90, 8'd90), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd90, 8'd90), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd120, 8'd120), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd60, 8'd77, 8'd77), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd0, 8'd0), 1'b0, all_zero);
    add_row(drive_cmd(8'd128, 8'd128, 8'd0, 8'd0), 1'b0, all_zero);
    c = '1; c.operation = OP_STOP;
    add_row(c, 1'b1, all_zero);
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].has_fixed, rows[i].fixed);
    // sender holds off until the block has delivered everything
    drain();

    // register phases, extremes included; each phase random drive and stop commands
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin apb_write(REG_DEAD_ZONE, 16'd0); apb_write(REG_RAMP_STEP, 16'd6554);
                  apb_write(REG_SPEED_LIMIT, 16'hFFFF); end
        1: begin apb_write(REG_DEAD_ZONE, 16'hFFFF); apb_write(REG_RAMP_STEP, 16'hFFFF);
                  apb_write(REG_SPEED_LIMIT, 16'd1); end
        2: begin apb_write(REG_DEAD_ZONE, 16'd8000); apb_write(REG_RAMP_STEP, 16'd1);
                  apb_write(REG_SPEED_LIMIT, 16'd40000); end
        3: begin apb_write(REG_DEAD_ZONE, 16'(($urandom_range(0, 20000))));
                  apb_write(REG_RAMP_STEP, 16'($urandom_range(1, 65535)));
                  apb_write(REG_SPEED_LIMIT, 16'($urandom_range(1, 65535))); end
        4: begin apb_write(REG_DEAD_ZONE, 16'd3000); apb_write(REG_RAMP_STEP, 16'd20000);
                  apb_write(REG_SPEED_LIMIT, 16'd65535); end
        default: begin apb_write(REG_DEAD_ZONE, 16'd0); apb_write(REG_RAMP_STEP, 16'd6554);
                  apb_write(REG_SPEED_LIMIT, 16'd30000); end
      endcase
      for (int i = 0; i < 215; i++) send_cmd(random_cmd(), 1'b0, all_zero);
      drain();
    end

    $display("covered %0d commands (%0d emergency stops), %0d results checked",
             cmds_sent, stops_sent, duties_checked);
    $display("six register settings including dead zone, step and limit extremes");
    if (error_count == 0 && duty_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
